[sv/prc_pkg.sv]
// Package for the polyline rectangle clipper: window bounds type, register
// indexes, sequencer states and shared constants.
// No dependencies.
package prc_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int CFG_W = 15;   // config register width
  localparam int CFG_IDX_W = 2;
  localparam int BND_W = 18;   // signed window bound, covers -1 .. 65533

  // Outcode bits: left, right, above, below
  localparam logic [3:0] OC_LEFT  = 4'd1;
  localparam logic [3:0] OC_RIGHT = 4'd2;
  localparam logic [3:0] OC_ABOVE = 4'd4;
  localparam logic [3:0] OC_BELOW = 4'd8;
  localparam logic [3:0] NO_PREV  = 4'd11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_TOP    = 2'd1,
    REG_WIN_WIDTH  = 2'd2,
    REG_WIN_HEIGHT = 2'd3
  } reg_idx_t;

  localparam logic [CFG_W-1:0] WIN_LEFT_RST   = 15'd0;
  localparam logic [CFG_W-1:0] WIN_TOP_RST    = 15'd0;
  localparam logic [CFG_W-1:0] WIN_WIDTH_RST  = 15'd640;
  localparam logic [CFG_W-1:0] WIN_HEIGHT_RST = 15'd480;

  typedef struct packed {
    logic signed [BND_W-1:0] xmin;
    logic signed [BND_W-1:0] xmax;
    logic signed [BND_W-1:0] ymin;
    logic signed [BND_W-1:0] ymax;
  } win_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PICK,
    B_MUL,
    B_DIV,
    B_CHECK,
    B_FIN
  } bstate_t;

endpackage

[sv/prc_front.sv]
// Front end: accepts vertex beats, computes outcodes, keeps the previous
// vertex and pushes candidate steps into the queue. Uses prc_pkg.
module prc_front import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  win_t                          win,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_first_vertex,
  input  logic signed [COORD_WIDTH-1:0] in_vert_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_y,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [4*COORD_WIDTH+7:0]      q_wdata
);

  localparam int EW = ((COORD_WIDTH > BND_W) ? COORD_WIDTH : BND_W) + 1;

  logic [COORD_WIDTH-1:0] last_x_r, last_y_r;
  logic [3:0]             last_code_r;
  logic signed [EW-1:0]   vx, vy;
  logic [3:0]             code;
  logic                   accept;

  assign vx = EW'(in_vert_x);
  assign vy = EW'(in_vert_y);

  always_comb begin
    code = 4'd0;
    if (vx < EW'(win.xmin)) code = code | OC_LEFT;
    else if (vx > EW'(win.xmax)) code = code | OC_RIGHT;
    if (vy < EW'(win.ymin)) code = code | OC_ABOVE;
    else if (vy > EW'(win.ymax)) code = code | OC_BELOW;
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  // trivially rejected steps never reach the back end
  assign q_push   = accept && !in_first_vertex && (last_code_r != NO_PREV) &&
                    ((last_code_r & code) == 4'd0);
  assign q_wdata  = {code, last_code_r, in_vert_x, in_vert_y, last_x_r, last_y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_code_r <= NO_PREV;
    end else if (accept) begin
      last_code_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_x_r <= in_vert_x;
      last_y_r <= in_vert_y;
    end
  end

endmodule

[sv/prc_queue.sv]
// Two-entry queue between front and back ends.
// Uses prc_pkg.
module prc_queue import prc_pkg::*; #(
  parameter int DW = 4*COORD_WIDTH_DEF+8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

[sv/prc_back.sv]
// Back end: clips queued steps against the window with one multiplier and
// a bit-serial divider, then holds the segment in the output register.
// Uses prc_pkg.
module prc_back import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  win_t                          win,
  input  logic                          q_empty,
  input  logic [4*COORD_WIDTH+7:0]      q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_seg_valid,
  output logic signed [COORD_WIDTH-1:0] out_start_x,
  output logic signed [COORD_WIDTH-1:0] out_start_y,
  output logic signed [COORD_WIDTH-1:0] out_end_x,
  output logic signed [COORD_WIDTH-1:0] out_end_y
);

  localparam int W     = COORD_WIDTH;
  localparam int EW    = ((W > BND_W) ? W : BND_W) + 1;
  localparam int MW    = EW - 1;
  localparam int PW    = 2 * MW;
  localparam int SW    = PW + 2;
  localparam int CNT_W = $clog2(PW + 1);

  bstate_t state_r, state_nxt;

  logic [W-1:0] ax_r, ay_r, bx_r, by_r;          // step ends as queued
  logic [W-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic [W-1:0] sx_r, sy_r, ex_r, ey_r;          // clipped ends
  logic [W-1:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic [3:0]   c0_r, c1_r, c0_nxt, c1_nxt;
  logic         end_sel_r, end_sel_nxt;          // 0: start end, 1: far end
  logic         axis_r, axis_nxt;                // 0: vertical edge, 1: horizontal
  logic [MW-1:0] ma_r, mb_r, div_r, ma_nxt, mb_nxt, div_nxt;
  logic          neg_r, neg_nxt;
  logic signed [EW-1:0] base_r, edge_r, base_nxt, edge_nxt;
  logic [PW-1:0] dvd_r, dvd_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  osx_r, osy_r, oex_r, oey_r;
  logic [W-1:0]  osx_nxt, osy_nxt, oex_nxt, oey_nxt;

  logic [3:0]           code;
  logic signed [EW-1:0] px, py, ox, oy, edgex, edgey;
  logic signed [EW-1:0] a, b, d;
  logic [MW:0]          trial;
  logic signed [SW-1:0] sq, t, lo, hi;
  logic                 in_range, out_free;

  always_comb begin
    code  = end_sel_r ? c1_r : c0_r;
    px    = end_sel_r ? EW'($signed(bx_r)) : EW'($signed(ax_r));
    py    = end_sel_r ? EW'($signed(by_r)) : EW'($signed(ay_r));
    ox    = end_sel_r ? EW'($signed(ax_r)) : EW'($signed(bx_r));
    oy    = end_sel_r ? EW'($signed(ay_r)) : EW'($signed(by_r));
    edgex = code[0] ? EW'(win.xmin) : EW'(win.xmax);
    edgey = code[2] ? EW'(win.ymin) : EW'(win.ymax);
    if (!axis_r) begin
      a = oy - py;
      b = edgex - px;
      d = ox - px;
    end else begin
      a = ox - px;
      b = edgey - py;
      d = oy - py;
    end
  end

  assign trial    = {rem_r, dvd_r[PW-1]};
  assign sq       = neg_r ? -SW'({2'b00, dvd_r}) : SW'({2'b00, dvd_r});
  assign t        = SW'(base_r) + sq;
  assign lo       = axis_r ? SW'(win.xmin) : SW'(win.ymin);
  assign hi       = axis_r ? SW'(win.xmax) : SW'(win.ymax);
  assign in_range = (t >= lo) && (t <= hi);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    ax_nxt = ax_r; ay_nxt = ay_r; bx_nxt = bx_r; by_nxt = by_r;
    sx_nxt = sx_r; sy_nxt = sy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    c0_nxt = c0_r; c1_nxt = c1_r;
    end_sel_nxt   = end_sel_r;
    axis_nxt      = axis_r;
    ma_nxt = ma_r; mb_nxt = mb_r; div_nxt = div_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    edge_nxt      = edge_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    osx_nxt = osx_r; osy_nxt = osy_r; oex_nxt = oex_r; oey_nxt = oey_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          {c1_nxt, c0_nxt, bx_nxt, by_nxt, ax_nxt, ay_nxt} = q_rdata;
          {bx_nxt, by_nxt} = q_rdata[4*W-1:2*W];
          sx_nxt = q_rdata[2*W-1:W];
          sy_nxt = q_rdata[W-1:0];
          ex_nxt = q_rdata[4*W-1:3*W];
          ey_nxt = q_rdata[3*W-1:2*W];
          end_sel_nxt = 1'b0;
          axis_nxt    = 1'b0;
          state_nxt   = B_PICK;
        end
      end
      B_PICK: begin
        if (code == 4'd0) begin
          if (end_sel_r) begin
            state_nxt = B_FIN;
          end else begin
            end_sel_nxt = 1'b1;
            axis_nxt    = 1'b0;
          end
        end else if (!axis_r && (code & (OC_LEFT | OC_RIGHT)) == 4'd0) begin
          axis_nxt = 1'b1;
        end else if (axis_r && (code & (OC_ABOVE | OC_BELOW)) == 4'd0) begin
          state_nxt = B_IDLE;   // no edge left to try
        end else if (d == '0) begin
          state_nxt = B_IDLE;   // zero divisor
        end else begin
          ma_nxt   = a[EW-1] ? MW'(-a) : MW'(a);
          mb_nxt   = b[EW-1] ? MW'(-b) : MW'(b);
          div_nxt  = d[EW-1] ? MW'(-d) : MW'(d);
          neg_nxt  = a[EW-1] ^ b[EW-1] ^ d[EW-1];
          base_nxt = axis_r ? px : py;
          edge_nxt = axis_r ? edgey : edgex;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        dvd_nxt   = ma_r * mb_r;
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(PW);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = MW'(trial - {1'b0, div_r});
          dvd_nxt = {dvd_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[MW-1:0];
          dvd_nxt = {dvd_r[PW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (in_range) begin
          if (!end_sel_r) begin
            sx_nxt = axis_r ? t[W-1:0] : edge_r[W-1:0];
            sy_nxt = axis_r ? edge_r[W-1:0] : t[W-1:0];
            end_sel_nxt = 1'b1;
            axis_nxt    = 1'b0;
            state_nxt   = B_PICK;
          end else begin
            ex_nxt = axis_r ? t[W-1:0] : edge_r[W-1:0];
            ey_nxt = axis_r ? edge_r[W-1:0] : t[W-1:0];
            state_nxt = B_FIN;
          end
        end else if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = B_PICK;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_FIN: begin
        if (out_free) begin
          osx_nxt = sx_r; osy_nxt = sy_r; oex_nxt = ex_r; oey_nxt = ey_r;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt; ay_r <= ay_nxt; bx_r <= bx_nxt; by_r <= by_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
    c0_r <= c0_nxt; c1_r <= c1_nxt;
    end_sel_r <= end_sel_nxt;
    axis_r    <= axis_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; div_r <= div_nxt;
    neg_r  <= neg_nxt;
    base_r <= base_nxt;
    edge_r <= edge_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    osx_r <= osx_nxt; osy_r <= osy_nxt; oex_r <= oex_nxt; oey_r <= oey_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_seg_valid = 1'b1;
  assign out_start_x   = osx_r;
  assign out_start_y   = osy_r;
  assign out_end_x     = oex_r;
  assign out_end_y     = oey_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (div_r != '0))
    else $error("divide by zero in clip");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (cnt_r != '0))
    else $error("divider count underrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FIN && !out_free) |=> (state_r == B_FIN))
    else $error("segment left while output busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE))
    else $error("pop outside idle");

endmodule

[sv/polyline_rect_clipper_unit.sv]
// Polyline clipper against a rectangular pixel window. Vertex beats enter on
// in_*, one clipped segment (or none) leaves on out_* per step. The front end
// takes a vertex every cycle while its two-entry queue has room, and drops
// trivially rejected steps itself without using the back end. The back end
// tries at most two sides per clipped end. Each try runs pick, multiply, a
// bit-serial divide over every product bit, and the range check. A queued
// step with both ends inside skips the multiply and divide; any step can be
// held further by an output stall. Window registers are to be written on
// cfg_* by the user only while idle; the block itself does not enforce it.
// Depends on prc_pkg, prc_front, prc_queue, prc_back.
module polyline_rect_clipper_unit import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_first_vertex,
  input  logic signed [COORD_WIDTH-1:0] in_vert_x,
  input  logic signed [COORD_WIDTH-1:0] in_vert_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_seg_valid,
  output logic signed [COORD_WIDTH-1:0] out_start_x,
  output logic signed [COORD_WIDTH-1:0] out_start_y,
  output logic signed [COORD_WIDTH-1:0] out_end_x,
  output logic signed [COORD_WIDTH-1:0] out_end_y
);

  localparam int DW = 4*COORD_WIDTH + 8;

  logic [CFG_W-1:0] left_r, top_r, width_r, height_r;
  win_t             win;
  logic             q_push, q_pop, q_full, q_empty;
  logic [DW-1:0]    q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= WIN_LEFT_RST;
      top_r    <= WIN_TOP_RST;
      width_r  <= WIN_WIDTH_RST;
      height_r <= WIN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIN_LEFT:   left_r   <= cfg_data;
        REG_WIN_TOP:    top_r    <= cfg_data;
        REG_WIN_WIDTH:  width_r  <= cfg_data;
        REG_WIN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    win.xmin = BND_W'(left_r);
    win.ymin = BND_W'(top_r);
    win.xmax = BND_W'(left_r) + BND_W'(width_r) - BND_W'(1);
    win.ymax = BND_W'(top_r) + BND_W'(height_r) - BND_W'(1);
  end

  prc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .win             (win),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_vertex (in_first_vertex),
    .in_vert_x       (in_vert_x),
    .in_vert_y       (in_vert_y),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_wdata         (q_wdata)
  );

  prc_queue #(.DW(DW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  prc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .win           (win),
    .q_empty       (q_empty),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_seg_valid (out_seg_valid),
    .out_start_x   (out_start_x),
    .out_start_y   (out_start_y),
    .out_end_x     (out_end_x),
    .out_end_y     (out_end_y)
  );

endmodule
